// ----- rtl/core/orl_pkg.sv -----
// orl_pkg: sizes, codes and shared types of the ordered record list
// used by orl_cell and ordered_record_list_unit; no dependencies
`default_nettype none

package orl_pkg;

   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 31;
   localparam int PAY_W    = 32;
   localparam int FCNT_W   = 6;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_LIST   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

   // broadcast controls from the sequencer to every cell
   typedef struct packed {
      logic             shift_en;
      logic             tail_load;
      logic [CNT_W-1:0] tail_index;
      logic             append_en;
      logic [CNT_W-1:0] append_index;
   } cell_ctl_type;

   function automatic logic [FCNT_W-1:0] count_field(input logic [CNT_W-1:0] cnt);
      logic [CNT_W+FCNT_W-1:0] wide;
      wide = {{FCNT_W{1'b0}}, cnt};
      return wide[FCNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/orl_cell.sv -----
// orl_cell: one record slot of the ring; takes its right neighbor,
// the head record at the ring tail, or a new record. uses orl_pkg
`default_nettype none

module orl_cell
   import orl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic [CNT_W-1:0] cell_index,
   input  wire cell_ctl_type ctl,
   input  wire entry_type    next_entry,
   input  wire entry_type    head_entry,
   input  wire entry_type    new_entry,
   output entry_type         entry
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.append_en && (cell_index == ctl.append_index)) begin
         entry_in = new_entry;
      end else if (ctl.shift_en) begin
         if (cell_index < ctl.tail_index) begin
            entry_in = next_entry;
         end else if ((cell_index == ctl.tail_index) && ctl.tail_load) begin
            entry_in = head_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ordered_record_list_unit.sv -----
// ordered_record_list_unit: ring of record cells plus the sequencer
// and the result register. uses orl_pkg and orl_cell
`default_nettype none

// channel  dir  handshake             payload
// req      in   req_valid/req_ready   action, entry_key, entry_payload
// rsp      out  rsp_valid/rsp_ready   status, out_key, out_payload,
//                                     entry_count, last_result
// append, unused action, full and empty cases: rsp beat in the cycle after accept
// delete: n rotation steps, then one rsp beat; list: n beats, one beat per
// cycle while rsp_ready is high; n is the record count
// delete and list rotate the cell ring through the head cell
// reset (synchronous) empties the list; record contents are left as is
// a stalled rsp beat holds the list rotation; req waits while busy

module ordered_record_list_unit
   import orl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_action,
   input  wire logic [KEY_W-1:0] req_entry_key,
   input  wire logic [PAY_W-1:0] req_entry_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [KEY_W-1:0]      rsp_out_key,
   output logic [PAY_W-1:0]      rsp_out_payload,
   output logic [FCNT_W-1:0]     rsp_entry_count,
   output logic                  rsp_last_result
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DELETE = 3'b010,
      S_LIST   = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic             found_ff, found_in;
   logic [KEY_W-1:0] key_ff, key_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   entry_type        out_ff, out_in;
   logic [CNT_W-1:0] rcount_ff, rcount_in;
   logic             last_ff, last_in;

   cell_ctl_type     ctl;
   entry_type        entries [CAPACITY];
   entry_type        new_entry;
   entry_type        head;
   logic             slot_free;
   logic             accept;
   logic             drop;

   assign new_entry.key     = req_entry_key;
   assign new_entry.payload = req_entry_payload;
   assign head              = entries[0];

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         orl_cell u_cell (
            .clock      (clock),
            .cell_index (CNT_W'(gi)),
            .ctl        (ctl),
            .next_entry (entries[(gi + 1) % CAPACITY]),
            .head_entry (head),
            .new_entry  (new_entry),
            .entry      (entries[gi])
         );
      end
   endgenerate

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   // first matching record at the head is dropped instead of recirculated
   assign drop      = !found_ff && (head.key == key_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      out_in       = out_ff;
      rcount_in    = rcount_ff;
      last_in      = last_ff;

      ctl.shift_en     = 1'b0;
      ctl.tail_load    = 1'b1;
      ctl.tail_index   = count_ff - CNT_W'(1);
      ctl.append_en    = 1'b0;
      ctl.append_index = count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               out_in       = '0;
               rcount_in    = count_ff;
               last_in      = 1'b1;
               key_in       = req_entry_key;
               step_in      = '0;
               found_in     = 1'b0;
               total_in     = count_ff;
               case (action_type'(req_action))
                  ACT_APPEND: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        ctl.append_en = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        rcount_in     = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_DELETE;
                     end
                  end
                  ACT_LIST: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_LIST;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_DELETE: begin
            ctl.shift_en  = 1'b1;
            ctl.tail_load = !drop;
            step_in       = step_ff + CNT_W'(1);
            if (drop) begin
               found_in = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
            if (step_ff == total_ff - CNT_W'(1)) begin
               rsp_valid_in = 1'b1;
               status_in    = (found_ff || drop) ? ST_OK : ST_NOT_FOUND;
               out_in       = '0;
               rcount_in    = drop ? count_ff - CNT_W'(1) : count_ff;
               last_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_LIST: begin
            if (slot_free) begin
               ctl.shift_en = 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               out_in       = head;
               rcount_in    = count_ff;
               last_in      = (step_ff == count_ff - CNT_W'(1));
               step_in      = step_ff + CNT_W'(1);
               if (step_ff == count_ff - CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      status_ff <= status_in;
      out_ff    <= out_in;
      rcount_ff <= rcount_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_key     = out_ff.key;
   assign rsp_out_payload = out_ff.payload;
   assign rsp_entry_count = count_field(rcount_ff);
   assign rsp_last_result = last_ff;

endmodule

`default_nettype wire
